### src/assert_macros.svh
// Assertion macros used by the checker file of the token scanner.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define ETS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under a synchronous reset.
`define ETS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/ets_pkg.sv
// Package of the expression token scanner: widths, codes, token and queue types.
// Helper functions for character classes, operator kinds and tokens. No dependencies.
`default_nettype none

package ets_pkg;

   localparam int INDEX_W     = 16;
   localparam int CHAR_W      = 8;
   localparam int KIND_W      = 5;
   localparam int KEY_CHARS   = 8;
   localparam int KEY_COUNT   = 8;
   localparam int KEY_W       = 64;
   localparam int WLEN_W      = $clog2(KEY_CHARS + 1);
   localparam int SLOT_W      = $clog2(KEY_CHARS);
   localparam int CSR_IDX_W   = $clog2(KEY_COUNT);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd0;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd1;
   localparam logic [KIND_W-1:0] KIND_STAR    = 5'd2;
   localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd4;
   localparam logic [KIND_W-1:0] KIND_OPEN    = 5'd6;
   localparam logic [KIND_W-1:0] KIND_CLOSE   = 5'd7;
   localparam logic [KIND_W-1:0] KIND_EQUAL   = 5'd8;
   localparam logic [KIND_W-1:0] KIND_BANG    = 5'd10;
   localparam logic [KIND_W-1:0] KIND_LESS    = 5'd12;
   localparam logic [KIND_W-1:0] KIND_GREATER = 5'd14;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd16;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd17;
   localparam logic [KIND_W-1:0] KIND_KEYWORD = 5'd18;
   localparam logic [KIND_W-1:0] KIND_END     = 5'd19;
   localparam logic [KIND_W-1:0] KIND_ILLEGAL = 5'd20;

   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_BANG    = 8'h21;
   localparam logic [CHAR_W-1:0] CH_OPEN    = 8'h28;
   localparam logic [CHAR_W-1:0] CH_CLOSE   = 8'h29;
   localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_PERIOD  = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_LESS    = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_GREATER = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_HELD   = 4'b0010,
      MODE_NUMBER = 4'b0100,
      MODE_WORD   = 4'b1000
   } scan_mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] start_idx;
      logic [INDEX_W-1:0] end_idx;
   } token_type;

   typedef struct packed {
      logic      two;
      token_type first;
      token_type second;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_word_start(input logic [CHAR_W-1:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
   endfunction

   function automatic logic [KIND_W-1:0] single_kind(input logic [CHAR_W-1:0] op);
      logic [KIND_W-1:0] k;
      case (op)
         CH_STAR:  k = KIND_STAR;
         CH_SLASH: k = KIND_SLASH;
         CH_EQUAL: k = KIND_EQUAL;
         CH_BANG:  k = KIND_BANG;
         CH_LESS:  k = KIND_LESS;
         default:  k = KIND_GREATER;
      endcase
      return k;
   endfunction

   function automatic logic op_pairs(input logic [CHAR_W-1:0] op,
                                     input logic [CHAR_W-1:0] c);
      logic p;
      if (op == CH_STAR || op == CH_SLASH) begin
         p = (c == op);
      end else begin
         p = (c == CH_EQUAL);
      end
      return p;
   endfunction

   function automatic token_type make_token(input logic [KIND_W-1:0]  k,
                                            input logic [INDEX_W-1:0] s,
                                            input logic [INDEX_W-1:0] e);
      token_type t;
      t.kind      = k;
      t.start_idx = s;
      t.end_idx   = e;
      return t;
   endfunction

endpackage

`default_nettype wire

### src/ets_ifs.sv
// Handshake interfaces of the token scanner: character requests and token responses.
// Depends on ets_pkg for field widths.
`default_nettype none

interface ets_req_if import ets_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface ets_rsp_if import ets_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  token_kind;
   logic [INDEX_W-1:0] start_index;
   logic [INDEX_W-1:0] end_index;
   logic               last_of_run;

   modport source (output valid, output token_kind, output start_index,
                   output end_index, output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input start_index,
                   input end_index, input last_of_run, output ready);
endinterface

`default_nettype wire

### src/expression_token_scanner_unit.sv
// Expression token scanner: one character accepted per cycle unless the queue is
// full; tokens pass the queue and the registered output stage, one token item per
// cycle unless the response is stalled. A character that yields two tokens holds
// the output stage for both; the four-entry queue absorbs that and any stall.
// Synchronous reset clears the scan state, the index and all keyword registers.
// Depends on ets_pkg, ets_ifs, ets_front, ets_queue and ets_back.
`default_nettype none

module expression_token_scanner_unit import ets_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   ets_req_if.sink                   req_chan,
   ets_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [KEY_W-1:0]     csr_wdata
);

   slot_type push;
   slot_type head;
   logic     push_ready;
   logic     pop;

   ets_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push_ready   (push_ready),
      .push         (push)
   );

   ets_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .push_ready (push_ready),
      .head       (head)
   );

   ets_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

### src/ets_front.sv
// Scanner front end: accepts characters, tracks the scan state and keyword registers,
// and forms up to two tokens per character. Depends on ets_pkg and ets_req_if.
`default_nettype none

module ets_front import ets_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   ets_req_if.sink                   req_chan,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [KEY_W-1:0]     csr_wdata,
   input  wire logic                 push_ready,
   output slot_type                  push
);

   logic [KEY_W-1:0]   keyword_ff [KEY_COUNT];
   scan_mode_type      mode_ff, mode_in;
   logic [CHAR_W-1:0]  held_ff, held_in;
   logic               period_ff, period_in;
   logic [INDEX_W-1:0] start_ff, start_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [INDEX_W-1:0] last_end_ff, last_end_in;
   logic [KEY_W-1:0]   wbuf_ff, wbuf_in;
   logic [WLEN_W-1:0]  wlen_ff, wlen_in;
   logic               stopped_ff, stopped_in;

   logic              accept;
   logic [CHAR_W-1:0] c;
   logic              is_kw;
   logic              consumed;
   logic              a_valid, b_valid;
   token_type         tok_a, tok_b;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign c              = req_chan.char_code;

   always_comb begin
      is_kw = 1'b0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (keyword_ff[k] != '0 && keyword_ff[k] == wbuf_ff) begin
            is_kw = 1'b1;
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      held_in     = held_ff;
      period_in   = period_ff;
      start_in    = start_ff;
      index_in    = index_ff;
      last_end_in = last_end_ff;
      wbuf_in     = wbuf_ff;
      wlen_in     = wlen_ff;
      stopped_in  = stopped_ff;
      consumed    = 1'b0;
      a_valid     = 1'b0;
      b_valid     = 1'b0;
      tok_a       = '0;
      tok_b       = '0;
      if (accept && !stopped_ff) begin
         case (mode_ff)
            MODE_HELD: begin
               a_valid = 1'b1;
               mode_in = MODE_IDLE;
               if (op_pairs(held_ff, c)) begin
                  tok_a    = make_token(single_kind(held_ff) + KIND_W'(1), start_ff, index_ff);
                  consumed = 1'b1;
               end else begin
                  tok_a = make_token(single_kind(held_ff), start_ff, start_ff);
               end
            end
            MODE_NUMBER: begin
               if (is_digit(c) || (c == CH_PERIOD && !period_ff)) begin
                  if (c == CH_PERIOD) begin
                     period_in = 1'b1;
                  end
                  last_end_in = index_ff;
                  consumed    = 1'b1;
               end else begin
                  a_valid = 1'b1;
                  tok_a   = make_token(KIND_NUMBER, start_ff, last_end_ff);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_WORD: begin
               if (is_word_start(c) || is_digit(c)) begin
                  if (wlen_ff < WLEN_W'(KEY_CHARS)) begin
                     wbuf_in[wlen_ff[SLOT_W-1:0]*CHAR_W +: CHAR_W] = c;
                     wlen_in = wlen_ff + WLEN_W'(1);
                  end
                  last_end_in = index_ff;
                  consumed    = 1'b1;
               end else begin
                  a_valid = 1'b1;
                  tok_a   = make_token(is_kw ? KIND_KEYWORD : KIND_IDENT, start_ff, last_end_ff);
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
            end
         endcase

         if (!consumed) begin
            case (c)
               CH_PLUS: begin
                  b_valid = 1'b1;
                  tok_b   = make_token(KIND_PLUS, index_ff, index_ff);
               end
               CH_MINUS: begin
                  b_valid = 1'b1;
                  tok_b   = make_token(KIND_MINUS, index_ff, index_ff);
               end
               CH_OPEN: begin
                  b_valid = 1'b1;
                  tok_b   = make_token(KIND_OPEN, index_ff, index_ff);
               end
               CH_CLOSE: begin
                  b_valid = 1'b1;
                  tok_b   = make_token(KIND_CLOSE, index_ff, index_ff);
               end
               CH_STAR, CH_SLASH, CH_EQUAL, CH_BANG, CH_LESS, CH_GREATER: begin
                  mode_in  = MODE_HELD;
                  held_in  = c;
                  start_in = index_ff;
               end
               CH_SPACE: begin
               end
               CH_NUL: begin
                  b_valid    = 1'b1;
                  tok_b      = make_token(KIND_END, index_ff, index_ff);
                  stopped_in = 1'b1;
               end
               default: begin
                  if (is_digit(c)) begin
                     mode_in     = MODE_NUMBER;
                     period_in   = 1'b0;
                     start_in    = index_ff;
                     last_end_in = index_ff;
                  end else if (is_word_start(c)) begin
                     mode_in     = MODE_WORD;
                     wbuf_in     = KEY_W'(c);
                     wlen_in     = WLEN_W'(1);
                     start_in    = index_ff;
                     last_end_in = index_ff;
                  end else begin
                     b_valid    = 1'b1;
                     tok_b      = make_token(KIND_ILLEGAL, index_ff, index_ff);
                     stopped_in = 1'b1;
                  end
               end
            endcase
         end

         if (index_ff != '1) begin
            index_in = index_ff + INDEX_W'(1);
         end
      end
   end

   always_comb begin
      push.valid        = a_valid || b_valid;
      push.entry.two    = a_valid && b_valid;
      push.entry.first  = a_valid ? tok_a : tok_b;
      push.entry.second = tok_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            keyword_ff[k] <= '0;
         end
      end else if (csr_write_en) begin
         keyword_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         held_ff     <= '0;
         period_ff   <= 1'b0;
         start_ff    <= '0;
         index_ff    <= '0;
         last_end_ff <= '0;
         wbuf_ff     <= '0;
         wlen_ff     <= '0;
         stopped_ff  <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         held_ff     <= held_in;
         period_ff   <= period_in;
         start_ff    <= start_in;
         index_ff    <= index_in;
         last_end_ff <= last_end_in;
         wbuf_ff     <= wbuf_in;
         wlen_ff     <= wlen_in;
         stopped_ff  <= stopped_in;
      end
   end

endmodule

`default_nettype wire

### src/ets_queue.sv
// Short queue of token entries between the scanner front end and the output stage.
// Depends on ets_pkg.
`default_nettype none

module ets_queue import ets_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire slot_type push,
   input  wire logic     pop,
   output logic          push_ready,
   output slot_type      head
);

   entry_type          store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = store_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### src/ets_back.sv
// Output stage: takes queue entries and delivers their tokens from a registered
// response, one item per cycle while ready. Depends on ets_pkg and ets_rsp_if.
`default_nettype none

module ets_back import ets_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire slot_type head,
   output logic          pop,
   ets_rsp_if.source     rsp_chan
);

   logic      out_valid_ff, out_valid_in;
   token_type out_tok_ff, out_tok_in;
   logic      out_last_ff, out_last_in;
   logic      pend_ff, pend_in;
   token_type second_ff, second_in;
   logic      load;

   assign load = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      pop          = 1'b0;
      out_valid_in = out_valid_ff;
      out_tok_in   = out_tok_ff;
      out_last_in  = out_last_ff;
      pend_in      = pend_ff;
      second_in    = second_ff;
      if (load) begin
         if (pend_ff) begin
            out_valid_in = 1'b1;
            out_tok_in   = second_ff;
            out_last_in  = 1'b1;
            pend_in      = 1'b0;
         end else if (head.valid) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            out_tok_in   = head.entry.first;
            out_last_in  = !head.entry.two;
            pend_in      = head.entry.two;
            second_in    = head.entry.second;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_tok_ff  <= out_tok_in;
      out_last_ff <= out_last_in;
      second_ff   <= second_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.token_kind  = out_tok_ff.kind;
   assign rsp_chan.start_index = out_tok_ff.start_idx;
   assign rsp_chan.end_index   = out_tok_ff.end_idx;
   assign rsp_chan.last_of_run = out_last_ff;

endmodule

`default_nettype wire

### src/ets_checker.sv
// Port-level checks on the token response channel of the scanner, bound to the top level.
// Depends on ets_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ets_checker import ets_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [KIND_W-1:0]  token_kind,
   input wire logic [INDEX_W-1:0] start_index,
   input wire logic [INDEX_W-1:0] end_index,
   input wire logic               last_of_run
);

   `ETS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(token_kind) && $stable(start_index) && $stable(end_index) && $stable(last_of_run), "stalled token item changed")
   `ETS_ASSERT_SAME(a_kind_range, clock, reset, rsp_valid, token_kind <= KIND_ILLEGAL, "token kind out of range")
   `ETS_ASSERT_SAME(a_span_order, clock, reset, rsp_valid, start_index <= end_index, "token ends before it starts")
   `ETS_ASSERT_SAME(a_stop_token, clock, reset, rsp_valid && (token_kind == KIND_END || token_kind == KIND_ILLEGAL), last_of_run && start_index == end_index, "bad end or illegal token")

endmodule

bind expression_token_scanner_unit ets_checker u_ets_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .token_kind  (rsp_chan.token_kind),
   .start_index (rsp_chan.start_index),
   .end_index   (rsp_chan.end_index),
   .last_of_run (rsp_chan.last_of_run)
);

`default_nettype wire
